@@ sv/btgb_pkg.sv @@
// ----------------------------------------------------------------------------
// btgb_pkg
// Shared constants, status types and linearization helpers for the bilinear
// texel gamma blend pipeline.
// ----------------------------------------------------------------------------
package btgb_pkg;

    localparam int NUM_CH     = 4;
    localparam int CH_RED     = 0;
    localparam int CH_GREEN   = 1;
    localparam int CH_BLUE    = 2;
    localparam int CH_ALPHA   = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int SQRT_BITS  = 8;
    localparam int TQ_W       = 19;

    localparam logic [17:0] SQRT_SCALE  = 18'd260100;
    localparam logic [7:0]  CHAN_MAX    = 8'hFF;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic int chan_lsb(input int c);
        int lsb;
        case (c)
            CH_RED:   lsb = 16;
            CH_GREEN: lsb = 8;
            CH_BLUE:  lsb = 0;
            default:  lsb = 24;
        endcase
        return lsb;
    endfunction

    function automatic logic [63:0] lin_color(input int unsigned c, input int unsigned lb);
        logic [63:0] cc;
        cc = 64'(c) * 64'(c);
        return ((cc << lb) + 64'd32512) / 64'd65025;
    endfunction

    function automatic logic [63:0] lin_alpha(input int unsigned a, input int unsigned lb);
        logic [63:0] aa;
        aa = 64'(a);
        return ((aa << lb) + 64'd127) / 64'd255;
    endfunction

endpackage

@@ sv/btgb_ifs.sv @@
// ----------------------------------------------------------------------------
// btgb_ifs
// Fragment request channel and pixel result channel.
// ----------------------------------------------------------------------------
interface btgb_frag_if;
    logic        valid;
    logic        ready;
    logic        textured;
    logic [31:0] texel_00;
    logic [31:0] texel_10;
    logic [31:0] texel_01;
    logic [31:0] texel_11;
    logic [8:0]  weight_u;
    logic [8:0]  weight_v;
    logic [31:0] dest_pixel;

    modport source (output valid, textured, texel_00, texel_10, texel_01, texel_11,
                    weight_u, weight_v, dest_pixel, input ready);
    modport sink   (input valid, textured, texel_00, texel_10, texel_01, texel_11,
                    weight_u, weight_v, dest_pixel, output ready);
endinterface

interface btgb_pix_if;
    logic        valid;
    logic        ready;
    logic [31:0] new_pixel;

    modport source (output valid, new_pixel, input ready);
    modport sink   (input valid, new_pixel, output ready);
endinterface

@@ sv/btgb_front.sv @@
// ----------------------------------------------------------------------------
// btgb_front
// Accepts fragment requests, resolves flat versus textured source, linearizes
// all pixels and forms the four bilinear weights.
// ----------------------------------------------------------------------------
module btgb_front #(
    parameter int WB = 8,
    parameter int LB = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 flat_color_we,
    input  logic [31:0]          flat_color_wdata,
    btgb_frag_if.sink            frag,
    input  btgb_pkg::q_stat_t    qs,
    output logic                 push,
    output logic [20*(LB+1)+4*(2*WB+1)-1:0] qdata
);

    localparam int LIN_W = LB + 1;
    localparam int WGT_W = 2 * WB + 1;
    localparam int UW    = (WB + 1 > 9) ? WB + 1 : 9;
    localparam int QW    = 20 * LIN_W + 4 * WGT_W;
    localparam logic [UW-1:0]    W_ONE_E = UW'(1) << WB;
    localparam logic [WB:0]      W_ONE   = (WB+1)'(1) << WB;
    localparam logic [WGT_W-1:0] W_FULL  = WGT_W'(1) << (2 * WB);

    logic [LIN_W-1:0] color_lut [256];
    logic [LIN_W-1:0] alpha_lut [256];

    for (genvar g = 0; g < 256; g++) begin : g_lut
        assign color_lut[g] = LIN_W'(btgb_pkg::lin_color(g, LB));
        assign alpha_lut[g] = LIN_W'(btgb_pkg::lin_alpha(g, LB));
    end

    logic [31:0]      flat_reg;
    logic             vld_reg;
    logic [QW-1:0]    data_reg;
    logic [QW-1:0]    data_next;
    logic             take;

    logic [31:0]      px [5];
    logic [WB:0]      uc, vc, iu, iv;
    logic [UW-1:0]    u_e, v_e;
    logic [WGT_W-1:0] wgt [4];
    logic [2*WB+1:0]  wp [4];

    assign push       = vld_reg && !qs.full;
    assign frag.ready = !vld_reg || !qs.full;
    assign take       = frag.valid && frag.ready;
    assign qdata      = data_reg;

    always_comb
    begin
        px[0] = frag.textured ? frag.texel_00 : flat_reg;
        px[1] = frag.texel_10;
        px[2] = frag.texel_01;
        px[3] = frag.texel_11;
        px[4] = frag.dest_pixel;

        u_e = UW'(frag.weight_u);
        v_e = UW'(frag.weight_v);
        uc  = (u_e > W_ONE_E) ? W_ONE : u_e[WB:0];
        vc  = (v_e > W_ONE_E) ? W_ONE : v_e[WB:0];
        iu  = W_ONE - uc;
        iv  = W_ONE - vc;
        wp[0] = (2*WB+2)'(iu) * (2*WB+2)'(iv);
        wp[1] = (2*WB+2)'(uc) * (2*WB+2)'(iv);
        wp[2] = (2*WB+2)'(iu) * (2*WB+2)'(vc);
        wp[3] = (2*WB+2)'(uc) * (2*WB+2)'(vc);
        for (int t = 0; t < 4; t++)
        begin
            wgt[t] = frag.textured ? wp[t][WGT_W-1:0] : ((t == 0) ? W_FULL : '0);
        end

        data_next = '0;
        for (int t = 0; t < 5; t++)
        begin
            for (int c = 0; c < btgb_pkg::NUM_CH; c++)
            begin
                if (c == btgb_pkg::CH_ALPHA)
                    data_next[(t < 4 ? (t*4+c)*LIN_W : 16*LIN_W+4*WGT_W+c*LIN_W) +: LIN_W]
                        = alpha_lut[px[t][btgb_pkg::chan_lsb(c) +: 8]];
                else
                    data_next[(t < 4 ? (t*4+c)*LIN_W : 16*LIN_W+4*WGT_W+c*LIN_W) +: LIN_W]
                        = color_lut[px[t][btgb_pkg::chan_lsb(c) +: 8]];
            end
        end
        for (int t = 0; t < 4; t++)
        begin
            data_next[16*LIN_W + t*WGT_W +: WGT_W] = wgt[t];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flat_reg <= '0;
            vld_reg  <= 1'b0;
        end
        else
        begin
            if (flat_color_we)
                flat_reg <= flat_color_wdata;
            if (take)
                vld_reg <= 1'b1;
            else if (push)
                vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            data_reg <= data_next;
    end

endmodule

@@ sv/btgb_fifo.sv @@
// ----------------------------------------------------------------------------
// btgb_fifo
// Short queue between the front and back halves.
// ----------------------------------------------------------------------------
module btgb_fifo #(
    parameter int WIDTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [WIDTH-1:0]   wdata,
    input  logic               pop,
    output logic [WIDTH-1:0]   rdata,
    output btgb_pkg::q_stat_t  qs
);

    logic [WIDTH-1:0]               mem [btgb_pkg::FIFO_DEPTH];
    logic [btgb_pkg::FIFO_AW-1:0]   wr_reg, rd_reg;
    logic [btgb_pkg::FIFO_AW:0]     cnt_reg;

    assign qs.empty = (cnt_reg == '0);
    assign qs.full  = (cnt_reg == (btgb_pkg::FIFO_AW+1)'(btgb_pkg::FIFO_DEPTH));
    assign rdata    = mem[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= wdata;
    end

endmodule

@@ sv/btgb_back.sv @@
// ----------------------------------------------------------------------------
// btgb_back
// Bilinear mix, alpha blend and gamma encode pipeline with a bit-per-stage
// square root.
// ----------------------------------------------------------------------------
module btgb_back #(
    parameter int WB = 8,
    parameter int LB = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  btgb_pkg::q_stat_t  qs,
    input  logic [20*(LB+1)+4*(2*WB+1)-1:0] qdata,
    output logic               pop,
    btgb_pix_if.source         pix
);

    localparam int LIN_W = LB + 1;
    localparam int WGT_W = 2 * WB + 1;
    localparam int PW    = LIN_W + WGT_W;
    localparam int SW    = PW + 2;
    localparam int BW    = 2 * LIN_W + 1;
    localparam int NS    = 5 + btgb_pkg::SQRT_BITS;
    localparam int TQ_W  = btgb_pkg::TQ_W;
    localparam logic [LIN_W-1:0] L_ONE  = LIN_W'(1) << LB;
    localparam logic [SW-1:0]    S_HALF = SW'(1) << (2 * WB - 1);
    localparam logic [BW-1:0]    B_HALF = BW'(1) << (LB - 1);
    localparam logic [LB+8:0]    A_HALF = (LB+9)'(1) << (LB - 1);

    logic             adv;
    logic [NS-1:0]    vld_reg;

    logic [PW-1:0]    prod_reg [4][4];
    logic [LIN_W-1:0] dst0_reg [4];
    logic [LIN_W-1:0] src1_reg [4];
    logic [LIN_W-1:0] dst1_reg [4];
    logic [2*LIN_W-1:0] bs_reg [4];
    logic [2*LIN_W-1:0] bd_reg [4];
    logic [LIN_W-1:0] res3_reg [4];
    logic [TQ_W-1:0]  tq4_reg  [3];
    logic [7:0]       al4_reg;
    logic [TQ_W-1:0]  tq_reg   [btgb_pkg::SQRT_BITS][3];
    logic [7:0]       n_reg    [btgb_pkg::SQRT_BITS][3];
    logic [7:0]       al_reg   [btgb_pkg::SQRT_BITS];

    logic [LIN_W-1:0] tex   [4][4];
    logic [WGT_W-1:0] wgt   [4];
    logic [LIN_W-1:0] dsth  [4];
    logic [SW-1:0]    ssum  [4];
    logic [BW-1:0]    bsum  [4];
    logic [LB+18:0]   tqp   [3];
    logic [LB+8:0]    ap;
    logic [7:0]       n_in  [btgb_pkg::SQRT_BITS][3];
    logic [7:0]       n_new [btgb_pkg::SQRT_BITS][3];
    logic [TQ_W-1:0]  tq_in [btgb_pkg::SQRT_BITS][3];
    logic [7:0]       cand  [btgb_pkg::SQRT_BITS][3];
    logic [9:0]       odd   [btgb_pkg::SQRT_BITS][3];
    logic [19:0]      sq    [btgb_pkg::SQRT_BITS][3];

    assign adv = !vld_reg[NS-1] || pix.ready;
    assign pop = adv && !qs.empty;

    always_comb
    begin
        for (int t = 0; t < 4; t++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                tex[t][c] = qdata[(t*4+c)*LIN_W +: LIN_W];
            end
            wgt[t]  = qdata[16*LIN_W + t*WGT_W +: WGT_W];
            dsth[t] = qdata[16*LIN_W + 4*WGT_W + t*LIN_W +: LIN_W];
        end
        for (int c = 0; c < 4; c++)
        begin
            ssum[c] = SW'(prod_reg[0][c]) + SW'(prod_reg[1][c]) + SW'(prod_reg[2][c])
                    + SW'(prod_reg[3][c]) + S_HALF;
            bsum[c] = BW'(bs_reg[c]) + BW'(bd_reg[c]) + B_HALF;
        end
        for (int c = 0; c < 3; c++)
        begin
            tqp[c] = (LB+19)'(res3_reg[c]) * (LB+19)'(btgb_pkg::SQRT_SCALE);
        end
        ap = (LB+9)'(res3_reg[btgb_pkg::CH_ALPHA]) * (LB+9)'(btgb_pkg::CHAN_MAX) + A_HALF;

        for (int k = 0; k < btgb_pkg::SQRT_BITS; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (k == 0)
                begin
                    n_in[k][c]  = '0;
                    tq_in[k][c] = tq4_reg[c];
                end
                else
                begin
                    n_in[k][c]  = n_reg[k-1][c];
                    tq_in[k][c] = tq_reg[k-1][c];
                end
                cand[k][c]  = n_in[k][c] | (8'h80 >> k);
                odd[k][c]   = {1'b0, cand[k][c], 1'b0} - 10'd1;
                sq[k][c]    = 20'(odd[k][c]) * 20'(odd[k][c]);
                n_new[k][c] = (sq[k][c] <= 20'(tq_in[k][c])) ? cand[k][c] : n_in[k][c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NS-2:0], !qs.empty};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 4; c++)
            begin
                for (int t = 0; t < 4; t++)
                begin
                    prod_reg[t][c] <= PW'(tex[t][c]) * PW'(wgt[t]);
                end
                dst0_reg[c] <= dsth[c];
                src1_reg[c] <= ssum[c][2*WB +: LIN_W];
                dst1_reg[c] <= dst0_reg[c];
                bs_reg[c]   <= (2*LIN_W)'(src1_reg[c]) *
                               (2*LIN_W)'(src1_reg[btgb_pkg::CH_ALPHA]);
                bd_reg[c]   <= (2*LIN_W)'(dst1_reg[c]) *
                               (2*LIN_W)'(L_ONE - src1_reg[btgb_pkg::CH_ALPHA]);
                res3_reg[c] <= bsum[c][LB +: LIN_W];
            end
            for (int c = 0; c < 3; c++)
            begin
                tq4_reg[c] <= tqp[c][LB +: TQ_W];
            end
            al4_reg <= (ap[LB+8:LB] > 9'(btgb_pkg::CHAN_MAX)) ? btgb_pkg::CHAN_MAX
                                                               : ap[LB+7:LB];
            for (int k = 0; k < btgb_pkg::SQRT_BITS; k++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    n_reg[k][c]  <= n_new[k][c];
                    tq_reg[k][c] <= tq_in[k][c];
                end
                al_reg[k] <= (k == 0) ? al4_reg : al_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign pix.valid     = vld_reg[NS-1];
    assign pix.new_pixel = {al_reg[btgb_pkg::SQRT_BITS-1],
                            n_reg[btgb_pkg::SQRT_BITS-1][btgb_pkg::CH_RED],
                            n_reg[btgb_pkg::SQRT_BITS-1][btgb_pkg::CH_GREEN],
                            n_reg[btgb_pkg::SQRT_BITS-1][btgb_pkg::CH_BLUE]};

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NS-1] && !pix.ready) |-> !pop)
        else $error("queue popped while output stalled");

    a_pop_fed: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> vld_reg[0])
        else $error("popped item lost at first stage");

endmodule

@@ sv/bilinear_texel_gamma_blend.sv @@
// ----------------------------------------------------------------------------
// bilinear_texel_gamma_blend
// Fragment shading and blend: bilinear texel filter in gamma-2 linear space,
// alpha blend over the destination pixel and gamma encode.
// ----------------------------------------------------------------------------
// Usage:
//   frag is a valid/ready request channel; each request carries four ARGB
//   texels, two weights, the textured flag and the destination pixel.
//   pix returns one packed ARGB new_pixel per request, in request order.
//   flat_color_we/flat_color_wdata load the flat color used for untextured
//   requests; write it only while no request is in flight.
// Throughput: one request per cycle, sustained while pix is ready, set by the fully
//   pipelined back end (one bit of the gamma square root per stage).
// A 4-entry queue separates the front (linearize, weights) from the back
//   (mix, blend, encode); a stalled pix channel freezes the back end, the
//   queue fills, then frag.ready drops.
// Reset: clears all valid state and the flat color to zero.
// ----------------------------------------------------------------------------
module bilinear_texel_gamma_blend #(
    parameter int WEIGHT_BITS = 8,
    parameter int LINEAR_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        flat_color_we,
    input  logic [31:0] flat_color_wdata,
    btgb_frag_if.sink   frag,
    btgb_pix_if.source  pix
);

    localparam int QW = 20 * (LINEAR_BITS + 1) + 4 * (2 * WEIGHT_BITS + 1);

    btgb_pkg::q_stat_t qs;
    logic              push;
    logic              pop;
    logic [QW-1:0]     wdata;
    logic [QW-1:0]     rdata;

    btgb_front #(.WB(WEIGHT_BITS), .LB(LINEAR_BITS)) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .flat_color_we    (flat_color_we),
        .flat_color_wdata (flat_color_wdata),
        .frag             (frag),
        .qs               (qs),
        .push             (push),
        .qdata            (wdata)
    );

    btgb_fifo #(.WIDTH(QW)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wdata),
        .pop   (pop),
        .rdata (rdata),
        .qs    (qs)
    );

    btgb_back #(.WB(WEIGHT_BITS), .LB(LINEAR_BITS)) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .qs    (qs),
        .qdata (rdata),
        .pop   (pop),
        .pix   (pix)
    );

endmodule
